/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_pkg
// shared types and constants of the scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned GainW  = 17;
	localparam int unsigned QuoW   = 16;
	localparam int unsigned ProdW  = 52;
	localparam int unsigned AddrW  = 3;

	localparam logic [GainW-1:0] OneQ16 = 17'h10000;

	// register indexes
	localparam logic REG_PROCESS_NOISE     = 1'b0;
	localparam logic REG_MEASUREMENT_NOISE = 1'b1;

	localparam logic [DataW-1:0] ProcessNoiseRst     = 32'd65;
	localparam logic [DataW-1:0] MeasurementNoiseRst = 32'd65536;
	localparam logic [DataW-1:0] CovarianceRst       = 32'd65536;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mul_x;
		logic upd_x;
		logic mul_p;
		logic upd_p;
		logic out_load;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;
	} sts_t;

endpackage

/* rtl/skf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_ctrl
// sequencer of one measurement through predict, divide and update steps
// ----------------------------------------------------------------------------
module skf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  skf_pkg::sts_t sts,
	output skf_pkg::cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_PREP = 8'b00000010,
		ST_DIV  = 8'b00000100,
		ST_MULX = 8'b00001000,
		ST_UPDX = 8'b00010000,
		ST_MULP = 8'b00100000,
		ST_UPDP = 8'b01000000,
		ST_DONE = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_MULX;
				end
			end
			ST_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = ST_UPDX;
			end
			ST_UPDX: begin
				cmd.upd_x = 1'b1;
				state_d   = ST_MULP;
			end
			ST_MULP: begin
				cmd.mul_p = 1'b1;
				state_d   = ST_UPDP;
			end
			ST_UPDP: begin
				cmd.upd_p = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/skf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skf_dp
// filter state, restoring gain divider, shared multiplier and saturation
// ----------------------------------------------------------------------------
module skf_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  skf_pkg::cmd_t              cmd,
	output skf_pkg::sts_t              sts,
	input  logic [skf_pkg::DataW-1:0]  process_noise,
	input  logic [skf_pkg::DataW-1:0]  measurement_noise,
	input  logic signed [skf_pkg::DataW-1:0] measurement,
	output logic signed [skf_pkg::DataW-1:0] estimate
);

	localparam int unsigned W = skf_pkg::DataW;

	// filter state
	logic signed [W-1:0] est_q;
	logic [W-1:0]        cov_q;

	// per-item registers
	logic [W-1:0]              z_q;
	logic [W-1:0]              pf_q;
	logic [W:0]                den_q;
	logic [W:0]                d_q;
	logic [W+1:0]              rem_q;
	logic [skf_pkg::QuoW-1:0]  quo_q;
	logic [3:0]                cnt_q;
	logic                      den_zero_q;
	logic                      r_zero_q;
	logic signed [skf_pkg::ProdW-1:0] prod_q;
	logic signed [W-1:0]       out_q;

	logic [W:0]                pf_sum;
	logic [W+1:0]              rem_sh;
	logic                      fits;
	logic [skf_pkg::GainW-1:0] gain;
	logic signed [skf_pkg::GainW:0] mul_a;
	logic signed [W+1:0]       mul_b;
	logic signed [skf_pkg::ProdW-1:0] mul_p;
	logic [W+4:0]              x_sum;
	logic [W-1:0]              x_sat;
	logic [W:0]                p_new;

	assign pf_sum = {1'b0, cov_q} + {1'b0, process_noise};
	assign rem_sh = {rem_q[W:0], 1'b0};
	assign fits   = (rem_sh >= {1'b0, den_q});

	assign sts.div_last = (cnt_q == 4'(skf_pkg::QuoW - 1));

	always_comb begin
		priority if (den_zero_q) begin
			gain = '0;
		end else if (r_zero_q) begin
			gain = skf_pkg::OneQ16;
		end else begin
			gain = {1'b0, quo_q};
		end
	end

	// shared multiplier: gain times innovation, or (1 - gain) times forecast
	always_comb begin
		if (cmd.mul_x) begin
			mul_a = $signed({1'b0, gain});
			mul_b = $signed({d_q[W], d_q});
		end else begin
			mul_a = $signed({1'b0, skf_pkg::OneQ16 - gain});
			mul_b = $signed({2'b00, pf_q});
		end
	end

	// full-width signed product
	assign mul_p = mul_a * mul_b;

	// floor shift is an arithmetic shift, then saturate to signed range
	assign x_sum = {{5{est_q[W-1]}}, est_q} + {prod_q[skf_pkg::ProdW-1], prod_q[51:16]};
	always_comb begin
		if (x_sum[W+4:W-1] == '0 || x_sum[W+4:W-1] == '1) begin
			x_sat = x_sum[W-1:0];
		end else if (x_sum[W+4]) begin
			x_sat = {1'b1, {(W-1){1'b0}}};
		end else begin
			x_sat = {1'b0, {(W-1){1'b1}}};
		end
	end

	assign p_new = prod_q[48:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q <= '0;
			cov_q <= skf_pkg::CovarianceRst;
		end else begin
			if (cmd.upd_x) begin
				est_q <= $signed(x_sat);
			end
			if (cmd.upd_p) begin
				cov_q <= p_new[W] ? '1 : p_new[W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			z_q  <= measurement;
			pf_q <= pf_sum[W] ? '1 : pf_sum[W-1:0];
		end
		if (cmd.prep) begin
			den_q      <= {1'b0, pf_q} + {1'b0, measurement_noise};
			den_zero_q <= (pf_q == '0) && (measurement_noise == '0);
			r_zero_q   <= (measurement_noise == '0);
			d_q        <= {z_q[W-1], z_q} - {est_q[W-1], est_q};
			rem_q      <= {2'b00, pf_q};
			quo_q      <= '0;
			cnt_q      <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
			quo_q <= {quo_q[skf_pkg::QuoW-2:0], fits};
			cnt_q <= cnt_q + 4'd1;
		end
		if (cmd.mul_x || cmd.mul_p) begin
			prod_q <= mul_p;
		end
		if (cmd.out_load) begin
			out_q <= est_q;
		end
	end

	assign estimate = out_q;

endmodule

/* rtl/scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// first-order kalman filter with unit gains on signed q16.16 measurements
// ----------------------------------------------------------------------------
//
// channel      | direction | handshake            | payload
// -------------+-----------+----------------------+---------------------------
// measurement  | in        | in_valid / in_stall   | measurement, signed q16.16
// estimate     | out       | out_valid / out_stall | estimate, signed q16.16
// config       | in        | apb psel/penable      | process / measurement noise
//
// one measurement goes from its transfer to its result through one load,
// one prep, the restoring gain divider, two multiply-update pairs on the
// shared multiplier and a done step that hands the result over
// in_stall is high from the transfer until the result enters the output
// register; a stalled output holds the next item in the done step
// reset sets estimate to zero, covariance to 1.0, q to 65 and r to 1.0
//
module scalar_kalman_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	// measurement channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [skf_pkg::DataW-1:0]  measurement,
	// estimate channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [skf_pkg::DataW-1:0]  estimate,
	// configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [skf_pkg::AddrW-1:0]         paddr,
	input  logic [skf_pkg::DataW-1:0]         pwdata,
	output logic [skf_pkg::DataW-1:0]         prdata,
	output logic                              pready
);

	logic [skf_pkg::DataW-1:0] process_noise_q;
	logic [skf_pkg::DataW-1:0] measurement_noise_q;
	logic                      cfg_wr;
	logic                      reg_idx;
	skf_pkg::cmd_t             cmd;
	skf_pkg::sts_t             sts;

	// register index is the word address; bits below are byte offset
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q     <= skf_pkg::ProcessNoiseRst;
			measurement_noise_q <= skf_pkg::MeasurementNoiseRst;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				skf_pkg::REG_PROCESS_NOISE:     process_noise_q     <= pwdata;
				skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			skf_pkg::REG_PROCESS_NOISE:     prdata = process_noise_q;
			skf_pkg::REG_MEASUREMENT_NOISE: prdata = measurement_noise_q;
			default:                        prdata = '0;
		endcase
	end

	// controller: sequencing and output valid
	skf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: state, divider, multiplier, output register
	skf_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.process_noise     (process_noise_q),
		.measurement_noise (measurement_noise_q),
		.measurement       (measurement),
		.estimate          (estimate)
	);

	// a transfer in starts the sequence, so the next cycle is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in flight");

	// at most one datapath step per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.mul_x,
			cmd.upd_x, cmd.mul_p, cmd.upd_p, cmd.out_load}))
		else $error("conflicting datapath commands");

	// a result never overwrites one that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output register overwritten while stalled");

	// a result shows up right after its handover
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result handed over but not presented");

endmodule

/* sim/tb_scalar_kalman_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// self-checking bench for the scalar kalman filter
// ----------------------------------------------------------------------------
//
// measurements go in over the valid/stall channel while the estimates are
// taken off the output channel; a scoreboard class carries its own copy of
// the filter state and noise settings, predicts each estimate at the input
// transfer and compares results in order
//
// the run opens with a directed block (field extremes, zero divisor, forecast
// overflow) and then sweeps random noise settings under three idling mixes:
// sender mostly busy, receiver mostly busy, then neither idling; a long
// receiver hold-off backs the block up, and every setting change waits for
// the filter to drain first
//
module tb_scalar_kalman_filter;

	localparam int unsigned CycleLimit     = 1000000;
	localparam int unsigned RxHoldCycles   = 400;
	localparam int unsigned TailCycles     = 40;
	localparam int unsigned ItemsPerSetting = 160;
	localparam int unsigned SettingsPerMix = 4;
	localparam int unsigned MaxReported    = 10;

	// ------------------------------------------------------------------------
	// scoreboard: filter state, noise settings and outstanding estimates
	// ------------------------------------------------------------------------
	class estimate_scoreboard;
		logic        [skf_pkg::DataW-1:0] q_noise;
		logic        [skf_pkg::DataW-1:0] r_noise;
		logic signed [skf_pkg::DataW-1:0] prev_estimate;
		logic        [skf_pkg::DataW-1:0] prev_covariance;
		logic signed [skf_pkg::DataW-1:0] pending_estimates[$];
		int unsigned                      errors;
		int unsigned                      measurements;
		int unsigned                      estimates;

		function new();
			q_noise         = skf_pkg::ProcessNoiseRst;
			r_noise         = skf_pkg::MeasurementNoiseRst;
			prev_estimate   = '0;
			prev_covariance = skf_pkg::CovarianceRst;
			errors          = 0;
			measurements    = 0;
			estimates       = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= MaxReported)
				$display("%t: %s", $realtime, msg);
		endfunction

		function void set_noise(logic idx, logic [skf_pkg::DataW-1:0] value);
			if (idx == skf_pkg::REG_PROCESS_NOISE)
				q_noise = value;
			else
				r_noise = value;
		endfunction

		function logic [skf_pkg::DataW-1:0] noise(logic idx);
			return (idx == skf_pkg::REG_PROCESS_NOISE) ? q_noise : r_noise;
		endfunction

		// one filter update: forecast, gain, estimate and covariance
		function logic signed [skf_pkg::DataW-1:0] filter_update(
			logic signed [skf_pkg::DataW-1:0] z);
			logic        [skf_pkg::DataW:0]   pf_sum;
			logic        [skf_pkg::DataW-1:0] pf;
			logic        [skf_pkg::DataW:0]   divisor;
			logic        [47:0]               quotient;
			logic        [skf_pkg::GainW-1:0] gain;
			logic signed [skf_pkg::DataW:0]   innovation;
			logic signed [50:0]               correction;
			logic signed [50:0]               x_wide;
			logic        [48:0]               p_wide;

			pf_sum = {1'b0, prev_covariance} + {1'b0, q_noise};
			pf     = pf_sum[skf_pkg::DataW] ? '1 : pf_sum[skf_pkg::DataW-1:0];

			// gain is zero when forecast and noise are both zero
			divisor = {1'b0, pf} + {1'b0, r_noise};
			if (divisor == '0) begin
				gain = '0;
			end else begin
				quotient = {pf, 16'h0000} / {15'b0, divisor};
				gain     = (quotient > 48'(skf_pkg::OneQ16)) ? skf_pkg::OneQ16
					: quotient[skf_pkg::GainW-1:0];
			end

			innovation = $signed({z[skf_pkg::DataW-1], z})
				- $signed({prev_estimate[skf_pkg::DataW-1], prev_estimate});
			correction = $signed({1'b0, gain}) * innovation;
			// arithmetic shift gives the floor toward minus infinity
			x_wide = prev_estimate + (correction >>> 16);
			if (x_wide[50:skf_pkg::DataW-1]
				!= {(52-skf_pkg::DataW){x_wide[skf_pkg::DataW-1]}})
				prev_estimate = x_wide[50] ? {1'b1, {(skf_pkg::DataW-1){1'b0}}}
					: {1'b0, {(skf_pkg::DataW-1){1'b1}}};
			else
				prev_estimate = x_wide[skf_pkg::DataW-1:0];

			p_wide = (skf_pkg::OneQ16 - gain) * pf;
			prev_covariance = (p_wide[48:16] > 33'hFFFFFFFF) ? '1 : p_wide[47:16];
			return prev_estimate;
		endfunction

		function void note_measurement(logic signed [skf_pkg::DataW-1:0] z);
			measurements++;
			pending_estimates.push_back(filter_update(z));
		endfunction

		function void check_estimate(logic signed [skf_pkg::DataW-1:0] got);
			logic signed [skf_pkg::DataW-1:0] want;
			estimates++;
			if (pending_estimates.size() == 0) begin
				flag($sformatf("estimate %h with no measurement outstanding", got));
			end else begin
				want = pending_estimates.pop_front();
				if (got !== want)
					flag($sformatf("estimate mismatch: expected %h, got %h", want, got));
			end
		endfunction

		function int unsigned pending();
			return pending_estimates.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// block under test
	// ------------------------------------------------------------------------
	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic signed [skf_pkg::DataW-1:0] measurement;
	logic                             out_valid;
	logic                             out_stall;
	logic signed [skf_pkg::DataW-1:0] estimate;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [skf_pkg::AddrW-1:0]        paddr;
	logic [skf_pkg::DataW-1:0]        pwdata;
	logic [skf_pkg::DataW-1:0]        prdata;
	logic                             pready;

	scalar_kalman_filter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.measurement (measurement),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.estimate    (estimate),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	estimate_scoreboard sb = new();

	// idling percentages, changed between mixes by the stimulus process
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	// long receiver hold-off, requested by the stimulus and counted below
	bit          hold_request = 1'b0;
	int unsigned hold_left    = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count   = 0;
	// level of the slow noisy signal used for well-formed sequences
	logic signed [skf_pkg::DataW-1:0] track_level = '0;
	logic signed [skf_pkg::DataW-1:0] last_sent   = '0;

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d estimates outstanding",
				cycle_count, sb.pending());
			$display("tb_scalar_kalman_filter: done, errors");
			$finish;
		end
	end

	// transfers seen at the clock edge, input side noted before output side
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid === 1'b1 && in_stall === 1'b0)
				sb.note_measurement(measurement);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				sb.check_estimate(estimate);
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = RxHoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// offer one measurement and return at the edge of its transfer;
	// valid stays high when the next one follows without a gap
	task automatic send_measurement(input logic signed [skf_pkg::DataW-1:0] z);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid    <= 1'b1;
		measurement <= z;
		last_sent    = z;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
	endtask

	// stop offering and wait until every estimate has come back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic write_noise(input logic idx, input logic [skf_pkg::DataW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_noise(idx, value);
		@(posedge clk);
	endtask

	task automatic read_back_noise(input logic idx);
		logic [skf_pkg::DataW-1:0] want;
		want     = sb.noise(idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		if (prdata !== want)
			sb.flag($sformatf("register %0d read back %h, expected %h", idx, prdata, want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// new q and r, written and read back while the filter is idle
	task automatic apply_noise(input logic [skf_pkg::DataW-1:0] q,
		input logic [skf_pkg::DataW-1:0] r);
		drain();
		write_noise(skf_pkg::REG_PROCESS_NOISE, q);
		write_noise(skf_pkg::REG_MEASUREMENT_NOISE, r);
		read_back_noise(skf_pkg::REG_PROCESS_NOISE);
		read_back_noise(skf_pkg::REG_MEASUREMENT_NOISE);
		settings_used++;
	endtask

	task automatic apply_random_noise();
		logic [skf_pkg::DataW-1:0] q;
		logic [skf_pkg::DataW-1:0] r;
		case ($urandom_range(0, 6))
			0: begin q = '0;                           r = '0;                           end
			1: begin q = '1;                           r = $urandom;                     end
			2: begin q = $urandom;                     r = '1;                           end
			3: begin q = $urandom_range(0, 32'h1000);  r = $urandom_range(0, 32'h40000); end
			4: begin q = $urandom_range(0, 32'h10000); r = $urandom;                     end
			5: begin q = '0;                           r = $urandom_range(0, 32'h100);   end
			default: begin q = $urandom;               r = $urandom;                     end
		endcase
		apply_noise(q, r);
	endtask

	// full-range values most often, then noisy tracks, extremes and repeats of the last value
	function automatic logic signed [skf_pkg::DataW-1:0] pick_measurement();
		logic signed [skf_pkg::DataW-1:0] jitter;
		int unsigned                      roll;
		roll   = $urandom_range(0, 99);
		jitter = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
		if (roll < 45)
			return $urandom;
		if (roll < 75) begin
			if ($urandom_range(0, 15) == 0)
				track_level = $urandom;
			return track_level + jitter;
		end
		if (roll < 90) begin
			case ($urandom_range(0, 4))
				0: return 32'sh7FFFFFFF;
				1: return 32'sh80000000;
				2: return 32'sh00000000;
				3: return 32'sh00000001;
				default: return -32'sh1;
			endcase
		end
		return last_sent;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		measurement <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of both registers
		read_back_noise(skf_pkg::REG_PROCESS_NOISE);
		read_back_noise(skf_pkg::REG_MEASUREMENT_NOISE);

		// directed: field extremes at reset noise settings
		send_measurement(32'sh00000000);
		send_measurement(32'sh7FFFFFFF);
		send_measurement(32'sh80000000);
		send_measurement(32'sh80000000);
		send_measurement(32'sh7FFFFFFF);
		send_measurement(32'sh00000001);
		send_measurement(-32'sh1);
		send_measurement(32'sh00010000);

		// forecast overflow: q at its maximum saturates p + q
		apply_noise('1, '1);
		send_measurement(32'sh7FFFFFFF);
		send_measurement(32'sh80000000);
		send_measurement(32'sh12345678);

		// no noise at all: full gain drives p to zero, then the divisor is zero
		apply_noise('0, '0);
		send_measurement(32'sh7FFFFFFF);
		send_measurement(32'sh80000000);
		send_measurement(32'sh00000000);
		send_measurement(32'sh55555555);

		// gain near zero, then near one with huge q
		apply_noise('0, '1);
		send_measurement(32'sh80000000);
		send_measurement(32'sh7FFFFFFF);
		apply_noise('1, '0);
		send_measurement(32'shAAAAAAAA);
		send_measurement(32'sh80000000);
		send_measurement(32'sh7FFFFFFF);

		// random sweep under three idling mixes
		for (int mix = 0; mix < 3; mix++) begin
			case (mix)
				0: begin tx_idle_pct = 24; rx_idle_pct = 61; end
				1: begin tx_idle_pct = 61; rx_idle_pct = 24; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int s = 0; s < SettingsPerMix; s++) begin
				apply_random_noise();
				for (int n = 0; n < ItemsPerSetting; n++) begin
					// back the block up with a long receiver hold-off
					if (s == 0 && n == 20 && mix != 1)
						hold_request = 1'b1;
					send_measurement(pick_measurement());
				end
			end
		end

		// end with the reset noise settings restored
		apply_noise(skf_pkg::ProcessNoiseRst, skf_pkg::MeasurementNoiseRst);
		for (int n = 0; n < 20; n++)
			send_measurement(pick_measurement());

		drain();
		repeat (TailCycles) @(posedge clk);
		if (sb.pending() != 0)
			sb.flag($sformatf("%0d estimates never arrived", sb.pending()));

		$display("covered %0d measurements and %0d estimates over %0d noise settings",
			sb.measurements, sb.estimates, settings_used);
		$display("idling mixes: sender 24/receiver 61, sender 61/receiver 24, none; %0d errors",
			sb.errors);
		if (sb.errors == 0)
			$display("tb_scalar_kalman_filter: done, clean");
		else
			$display("tb_scalar_kalman_filter: done, errors");
		$finish;
	end

endmodule
